FILE: rtl/core/rlf_pkg.sv
package rlf_pkg;

   localparam int LevelWidth = 8;
   localparam int ProdWidth  = 2 * LevelWidth;
   localparam int CountWidth = $clog2(ProdWidth);
   localparam int Channels   = 3;
   localparam int ChanWidth  = 2;

   localparam logic [LevelWidth-1:0] PwmTop = 8'd255;

   localparam logic ActStart = 1'b0;
   localparam logic ActTick  = 1'b1;

   typedef logic [LevelWidth-1:0] level_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_WAIT
   } seq_state_type;

   typedef struct packed {
      logic      start;
      level_type index;
      level_type distance;
      level_type total;
   } div_req_type;

   typedef struct packed {
      logic      done;
      level_type quotient;
   } div_rsp_type;

endpackage

FILE: rtl/core/rlf_if.sv
interface rlf_req_if;
   logic              valid;
   logic              ready;
   logic              action;
   rlf_pkg::level_type start_red;
   rlf_pkg::level_type start_green;
   rlf_pkg::level_type start_blue;
   rlf_pkg::level_type end_red;
   rlf_pkg::level_type end_green;
   rlf_pkg::level_type end_blue;
   rlf_pkg::level_type steps;

   modport source (
      output valid, action, start_red, start_green, start_blue,
             end_red, end_green, end_blue, steps,
      input  ready
   );
   modport sink (
      input  valid, action, start_red, start_green, start_blue,
             end_red, end_green, end_blue, steps,
      output ready
   );
endinterface

interface rlf_rsp_if;
   logic valid;
   logic ready;
   logic red_drive;
   logic green_drive;
   logic blue_drive;
   logic fading;

   modport source (
      output valid, red_drive, green_drive, blue_drive, fading,
      input  ready
   );
   modport sink (
      input  valid, red_drive, green_drive, blue_drive, fading,
      output ready
   );
endinterface

FILE: rtl/core/rlf_divu.sv
module rlf_divu (
   input  logic                 clock,
   input  logic                 reset,
   input  rlf_pkg::div_req_type div_req,
   output rlf_pkg::div_rsp_type div_rsp
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [rlf_pkg::CountWidth-1:0]     cnt_ff, cnt_in;
   logic [rlf_pkg::ProdWidth-1:0]      quo_ff, quo_in;
   logic [rlf_pkg::LevelWidth-1:0]     rem_ff, rem_in;
   logic [rlf_pkg::LevelWidth:0]       shifted;
   logic [rlf_pkg::LevelWidth:0]       divisor;
   logic [rlf_pkg::LevelWidth:0]       diff;
   logic                               fits;

   assign shifted = {rem_ff, quo_ff[rlf_pkg::ProdWidth-1]};
   assign divisor = {1'b0, div_req.total};
   assign diff    = shifted - divisor;
   assign fits    = (shifted >= divisor);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.index * div_req.distance;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[rlf_pkg::ProdWidth-2:0], fits};
         rem_in = fits ? diff[rlf_pkg::LevelWidth-1:0] : shifted[rlf_pkg::LevelWidth-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rlf_pkg::CountWidth'(rlf_pkg::ProdWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff[rlf_pkg::LevelWidth-1:0];

endmodule

FILE: rtl/core/rgb_linear_fade_pwm.sv
// Three-channel LED cross-fade engine with PWM. A start transfer loads a start colour, an end
// colour and a step count and answers at once; each tick transfer of a fade advances the PWM
// counter and returns the three drive levels and the fading flag (else all zero). Ticks can follow
// back to back while the response side takes each result, except the tick that closes a PWM period
// of a continuing fade: the new levels origin +/- (index * distance) / steps are then computed
// channel by channel in one shared multiplier and bit-serial divider, and the block takes no
// transfer until each channel has had its launch state, sixteen divide iterations and level write-back.
module rgb_linear_fade_pwm (
   input logic       clock,
   input logic       reset,
   rlf_req_if.sink   req_ch,
   rlf_rsp_if.source rsp_ch
);

   rlf_pkg::seq_state_type state_ff, state_in;
   logic [rlf_pkg::ChanWidth-1:0] ch_ff, ch_in;

   rlf_pkg::level_type tick_count_ff, tick_count_in;
   rlf_pkg::level_type step_index_ff, step_index_in;
   rlf_pkg::level_type step_total_ff, step_total_in;
   rlf_pkg::level_type origin_ff [rlf_pkg::Channels];
   rlf_pkg::level_type origin_in [rlf_pkg::Channels];
   rlf_pkg::level_type dist_ff [rlf_pkg::Channels];
   rlf_pkg::level_type dist_in [rlf_pkg::Channels];
   logic               down_ff [rlf_pkg::Channels];
   logic               down_in [rlf_pkg::Channels];
   rlf_pkg::level_type level_ff [rlf_pkg::Channels];
   rlf_pkg::level_type level_in [rlf_pkg::Channels];
   logic               active_ff, active_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [rlf_pkg::Channels-1:0] drive_ff, drive_in;
   logic fading_ff, fading_in;

   rlf_pkg::level_type start_lvl [rlf_pkg::Channels];
   rlf_pkg::level_type end_lvl [rlf_pkg::Channels];
   rlf_pkg::level_type tick_next;
   rlf_pkg::level_type step_next;
   logic req_fire;
   logic launch;
   logic level_wr;

   rlf_pkg::div_req_type div_req;
   rlf_pkg::div_rsp_type div_rsp;

   rlf_divu u_divu (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign start_lvl[0] = req_ch.start_red;
   assign start_lvl[1] = req_ch.start_green;
   assign start_lvl[2] = req_ch.start_blue;
   assign end_lvl[0]   = req_ch.end_red;
   assign end_lvl[1]   = req_ch.end_green;
   assign end_lvl[2]   = req_ch.end_blue;

   assign req_ch.ready = (state_ff == rlf_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign tick_next    = tick_count_ff + 1'b1;
   assign step_next    = step_index_ff + 1'b1;
   assign launch       = req_fire && (req_ch.action == rlf_pkg::ActTick) && active_ff &&
                         (tick_next >= rlf_pkg::PwmTop) && (step_next < step_total_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rlf_pkg::ST_IDLE: begin
            if (launch) begin
               state_in = rlf_pkg::ST_LAUNCH;
            end
         end
         rlf_pkg::ST_LAUNCH: begin
            state_in = rlf_pkg::ST_WAIT;
         end
         rlf_pkg::ST_WAIT: begin
            if (div_rsp.done) begin
               if (ch_ff == rlf_pkg::ChanWidth'(rlf_pkg::Channels - 1)) begin
                  state_in = rlf_pkg::ST_IDLE;
               end else begin
                  state_in = rlf_pkg::ST_LAUNCH;
               end
            end
         end
         default: begin
            state_in = rlf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      div_req.start    = 1'b0;
      div_req.index    = step_index_ff;
      div_req.distance = dist_ff[ch_ff];
      div_req.total    = step_total_ff;
      level_wr         = 1'b0;
      case (state_ff)
         rlf_pkg::ST_LAUNCH: begin
            div_req.start = 1'b1;
         end
         rlf_pkg::ST_WAIT: begin
            level_wr = div_rsp.done;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ch_in         = ch_ff;
      tick_count_in = tick_count_ff;
      step_index_in = step_index_ff;
      step_total_in = step_total_ff;
      origin_in     = origin_ff;
      dist_in       = dist_ff;
      down_in       = down_ff;
      level_in      = level_ff;
      active_in     = active_ff;
      rsp_valid_in  = rsp_valid_ff;
      drive_in      = drive_ff;
      fading_in     = fading_ff;

      if (state_ff == rlf_pkg::ST_IDLE) begin
         ch_in = '0;
      end

      if (req_fire) begin
         rsp_valid_in = 1'b1;
         drive_in     = '0;
         fading_in    = 1'b0;
         if (req_ch.action == rlf_pkg::ActStart) begin
            for (int c = 0; c < rlf_pkg::Channels; c++) begin
               origin_in[c] = start_lvl[c];
               level_in[c]  = start_lvl[c];
               down_in[c]   = (start_lvl[c] > end_lvl[c]);
               dist_in[c]   = (start_lvl[c] > end_lvl[c]) ? start_lvl[c] - end_lvl[c]
                                                          : end_lvl[c] - start_lvl[c];
            end
            step_total_in = req_ch.steps;
            step_index_in = '0;
            tick_count_in = '0;
            active_in     = (req_ch.steps != '0);
            fading_in     = (req_ch.steps != '0);
         end else if (active_ff) begin
            for (int c = 0; c < rlf_pkg::Channels; c++) begin
               drive_in[c] = (level_ff[c] >= tick_next);
            end
            fading_in = 1'b1;
            if (tick_next >= rlf_pkg::PwmTop) begin
               tick_count_in = '0;
               step_index_in = step_next;
               if (step_next >= step_total_ff) begin
                  active_in = 1'b0;
               end
            end else begin
               tick_count_in = tick_next;
            end
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (level_wr) begin
         level_in[ch_ff] = down_ff[ch_ff] ? origin_ff[ch_ff] - div_rsp.quotient
                                          : origin_ff[ch_ff] + div_rsp.quotient;
         ch_in = ch_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rlf_pkg::ST_IDLE;
         ch_ff         <= '0;
         tick_count_ff <= '0;
         step_index_ff <= '0;
         step_total_ff <= '0;
         active_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int c = 0; c < rlf_pkg::Channels; c++) begin
            origin_ff[c] <= '0;
            dist_ff[c]   <= '0;
            down_ff[c]   <= 1'b0;
            level_ff[c]  <= '0;
         end
      end else begin
         state_ff      <= state_in;
         ch_ff         <= ch_in;
         tick_count_ff <= tick_count_in;
         step_index_ff <= step_index_in;
         step_total_ff <= step_total_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
         origin_ff     <= origin_in;
         dist_ff       <= dist_in;
         down_ff       <= down_in;
         level_ff      <= level_in;
      end
      drive_ff  <= drive_in;
      fading_ff <= fading_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.red_drive   = drive_ff[0];
   assign rsp_ch.green_drive = drive_ff[1];
   assign rsp_ch.blue_drive  = drive_ff[2];
   assign rsp_ch.fading      = fading_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == rlf_pkg::ST_WAIT)
      else $error("divider finished outside of the wait state");

   a_compute_when_active: assert property (@(posedge clock) disable iff (reset)
      state_ff != rlf_pkg::ST_IDLE |-> active_ff)
      else $error("level computation while no fade is active");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> step_index_ff < step_total_ff)
      else $error("step index beyond step count during a fade");

   a_rsp_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("input transfer produced no result");

endmodule
